/* hdl/rtpd_pkg.sv */
package rtpd_pkg;

	// Packet kinds tracked by the front end
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_STAP   = 2'd2,
		KIND_FU     = 2'd3
	} kind_t;

	// STAP-A parsing phases
	typedef enum logic [1:0] {
		PH_SIZE_HI = 2'd0,
		PH_SIZE_LO = 2'd1,
		PH_COPY    = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	// Input request: one payload byte with packet framing
	typedef struct packed {
		logic [7:0]  in_byte;
		logic        first_of_packet;
		logic        last_of_packet;
		logic [15:0] payload_length;
	} in_item_t;

	// Output request: one Annex-B byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// Work handed from front to back: optional start code, optional data byte
	typedef struct packed {
		logic       start;
		logic       has_byte;
		logic [7:0] data;
	} cmd_t;

	localparam int CMD_DEPTH = 4;

	localparam logic [4:0]  NAL_SINGLE_MAX = 5'd23;
	localparam logic [4:0]  NAL_STAP       = 5'd24;
	localparam logic [4:0]  NAL_FU         = 5'd28;
	localparam logic [7:0]  NRI_MASK       = 8'he0;
	localparam logic [15:0] POS_MAX        = 16'hffff;
	localparam logic [15:0] FU_MIN_LEN     = 16'd2;
	localparam logic [15:0] STAP_MIN_REM   = 16'd2;
	localparam logic [15:0] FU_HDR_POS     = 16'd1;

	// Output sequence slots: three zero bytes, a one byte, then the data byte
	localparam logic [2:0] SLOT_ZERO  = 3'd0;
	localparam logic [2:0] SLOT_ONE   = 3'd3;
	localparam logic [2:0] SLOT_DATA  = 3'd4;

endpackage

/* hdl/h264_rtp_depacketizer.sv */
// Channel   Handshake            Payload
// input     push / full          packet_item  (in_item_t: byte, first, last, length)
// output    empty / pop          stream_item  (out_item_t: byte, last_of_run)
//
// One payload byte is taken per cycle while full is low; each result byte
// leaves one per cycle while pop is high. A start code adds four output bytes,
// so a byte that opens a NAL unit yields five, or four for a bare start code;
// full rises only when the command queue between front and back fills. A
// request's first result goes via a queue write, then a load when the back is free.
// arst_n clears packet state, queue and output register; no clearing pass.
// A stall on pop holds the output byte and backs up into the queue.
module h264_rtp_depacketizer #(
	parameter int CMD_DEPTH = rtpd_pkg::CMD_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rtpd_pkg::in_item_t  packet_item,
	output logic                empty,
	input  logic                pop,
	output rtpd_pkg::out_item_t stream_item
);

	logic           cmd_push;
	rtpd_pkg::cmd_t cmd_wr;
	rtpd_pkg::cmd_t cmd_rd;
	logic           cmd_valid;
	logic           cmd_pop;

	rtpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.packet_item (packet_item),
		.cmd_push    (cmd_push),
		.cmd         (cmd_wr)
	);

	rtpd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd_wr),
		.full    (full),
		.rd      (cmd_pop),
		.rd_data (cmd_rd),
		.valid   (cmd_valid)
	);

	rtpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd_rd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.stream_item (stream_item)
	);

endmodule

/* hdl/rtpd_front.sv */
module rtpd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  rtpd_pkg::in_item_t packet_item,
	output logic               cmd_push,
	output rtpd_pkg::cmd_t     cmd
);

	rtpd_pkg::kind_t  kind_q, kind_d;
	rtpd_pkg::phase_t phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  size_hi_q, size_hi_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  ind_q, ind_d;

	logic        accept;
	logic [4:0]  hdr_type;
	logic [15:0] rem;
	logic [15:0] size_val;
	logic [15:0] left_dec;

	assign accept   = push && !full;
	assign hdr_type = packet_item.in_byte[4:0];
	assign rem      = packet_item.payload_length - pos_q;
	assign size_val = {size_hi_q, packet_item.in_byte};
	assign left_dec = (left_q != '0) ? 16'(left_q - 16'd1) : left_q;

	// Hold packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= rtpd_pkg::KIND_NONE;
			phase_q   <= rtpd_pkg::PH_SIZE_HI;
			pos_q     <= '0;
			size_hi_q <= '0;
			left_q    <= '0;
			ind_q     <= '0;
		end else if (accept) begin
			kind_q    <= kind_d;
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			size_hi_q <= size_hi_d;
			left_q    <= left_d;
			ind_q     <= ind_d;
		end
	end

	// Classify the byte and advance packet state
	always_comb begin
		kind_d    = kind_q;
		phase_d   = phase_q;
		pos_d     = pos_q;
		size_hi_d = size_hi_q;
		left_d    = left_q;
		ind_d     = ind_q;
		cmd       = '0;
		cmd.data  = packet_item.in_byte;

		if (packet_item.first_of_packet) begin
			pos_d     = '0;
			phase_d   = rtpd_pkg::PH_SIZE_HI;
			size_hi_d = '0;
			left_d    = '0;
			if (hdr_type <= rtpd_pkg::NAL_SINGLE_MAX) begin
				kind_d       = rtpd_pkg::KIND_SINGLE;
				cmd.start    = 1'b1;
				cmd.has_byte = (packet_item.payload_length != '0);
			end else if (hdr_type == rtpd_pkg::NAL_STAP) begin
				kind_d = rtpd_pkg::KIND_STAP;
			end else if (hdr_type == rtpd_pkg::NAL_FU &&
			             packet_item.payload_length > rtpd_pkg::FU_MIN_LEN) begin
				kind_d = rtpd_pkg::KIND_FU;
				ind_d  = packet_item.in_byte;
			end else begin
				kind_d = rtpd_pkg::KIND_NONE;
			end
		end else if (kind_q != rtpd_pkg::KIND_NONE && pos_q < packet_item.payload_length) begin
			case (kind_q)
				rtpd_pkg::KIND_SINGLE: begin
					cmd.has_byte = 1'b1;
				end
				rtpd_pkg::KIND_FU: begin
					if (pos_q == rtpd_pkg::FU_HDR_POS) begin
						// Rebuild the NAL header on the start fragment
						if (packet_item.in_byte[7]) begin
							cmd.start    = 1'b1;
							cmd.has_byte = 1'b1;
							cmd.data     = (ind_q & rtpd_pkg::NRI_MASK) |
							               {3'b000, packet_item.in_byte[4:0]};
						end
					end else begin
						cmd.has_byte = 1'b1;
					end
				end
				rtpd_pkg::KIND_STAP: begin
					case (phase_q)
						rtpd_pkg::PH_SIZE_HI: begin
							if (rem > rtpd_pkg::STAP_MIN_REM) begin
								size_hi_d = packet_item.in_byte;
								phase_d   = rtpd_pkg::PH_SIZE_LO;
							end else begin
								phase_d = rtpd_pkg::PH_DISCARD;
							end
						end
						rtpd_pkg::PH_SIZE_LO: begin
							if (size_val <= 16'(rem - 16'd1)) begin
								cmd.start = 1'b1;
								if (size_val == '0) begin
									phase_d = rtpd_pkg::PH_SIZE_HI;
								end else begin
									left_d  = size_val;
									phase_d = rtpd_pkg::PH_COPY;
								end
							end else begin
								phase_d = rtpd_pkg::PH_DISCARD;
							end
						end
						rtpd_pkg::PH_COPY: begin
							cmd.has_byte = 1'b1;
							left_d       = left_dec;
							if (left_dec == '0) begin
								phase_d = rtpd_pkg::PH_SIZE_HI;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end

		// Advance position, saturating
		if (kind_d != rtpd_pkg::KIND_NONE && pos_d != rtpd_pkg::POS_MAX) begin
			pos_d = 16'(pos_d + 16'd1);
		end

		// Close the packet on its last byte
		if (packet_item.last_of_packet) begin
			kind_d  = rtpd_pkg::KIND_NONE;
			pos_d   = '0;
			phase_d = rtpd_pkg::PH_SIZE_HI;
			left_d  = '0;
		end

		cmd_push = accept && (cmd.start || cmd.has_byte);
	end

endmodule

/* hdl/rtpd_fifo.sv */
module rtpd_fifo #(
	parameter int DEPTH = rtpd_pkg::CMD_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  rtpd_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd,
	output rtpd_pkg::cmd_t rd_data,
	output logic           valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rtpd_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == FULL_CNT);
	assign valid   = (count_q != '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && valid;
	assign rd_data = slot_q[rptr_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : PW'(wptr_q + 1'b1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : PW'(rptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

endmodule

/* hdl/rtpd_back.sv */
module rtpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  rtpd_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output rtpd_pkg::out_item_t stream_item
);

	logic           cur_valid_q;
	rtpd_pkg::cmd_t cur_q;
	logic [2:0]     slot_q;
	logic           at_last;
	logic           take;

	assign empty   = !cur_valid_q;
	assign at_last = (slot_q == rtpd_pkg::SLOT_DATA) ||
	                 (slot_q == rtpd_pkg::SLOT_ONE && !cur_q.has_byte);
	assign take    = !cur_valid_q || (pop && at_last);
	assign cmd_pop = take && cmd_valid;

	// Select the byte for the current slot
	always_comb begin
		if (slot_q == rtpd_pkg::SLOT_DATA) begin
			stream_item.out_byte = cur_q.data;
		end else if (slot_q == rtpd_pkg::SLOT_ONE) begin
			stream_item.out_byte = 8'd1;
		end else begin
			stream_item.out_byte = 8'd0;
		end
		stream_item.last_of_run = at_last;
	end

	// Load the next request or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			slot_q      <= rtpd_pkg::SLOT_ZERO;
		end else if (take) begin
			cur_valid_q <= cmd_valid;
			slot_q      <= cmd.start ? rtpd_pkg::SLOT_ZERO : rtpd_pkg::SLOT_DATA;
		end else if (pop) begin
			slot_q <= 3'(slot_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= cmd;
		end
	end

endmodule
